// ===== rtl/gasa_pkg.sv =====
package gasa_pkg;

  localparam int MaxSlots = 64;
  localparam int SlotIdxW = $clog2(MaxSlots);
  localparam int CountW = $clog2(MaxSlots + 1);
  localparam int DimW = 14;
  localparam int CoordW = 13;
  localparam int BlkW = 4;
  localparam int CfgIdxW = 2;
  localparam int MinSlotDim = 2;
  localparam int AtlasReset = 2048;

  localparam logic [CfgIdxW-1:0] RegAtlasWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAtlasHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlockWidth = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBlockHeight = 2'd3;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef struct packed {
    logic op;
    logic [DimW-1:0] req_width;
    logic [DimW-1:0] req_height;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [CoordW-1:0] place_x;
    logic [CoordW-1:0] place_y;
  } res_t;

  typedef struct packed {
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } slot_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SPLIT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [SlotIdxW-1:0] idx;
    slot_t first;
    slot_t second;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SCAN,
    ST_SPLIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/gasa_cell.sv =====
module gasa_cell (
  input  logic clk,
  input  logic [gasa_pkg::SlotIdxW-1:0] pos,
  input  gasa_pkg::cell_cmd_t cmd,
  input  gasa_pkg::slot_t left_slot,
  input  gasa_pkg::slot_t right_slot,
  output gasa_pkg::slot_t slot
);
  import gasa_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_LOAD: begin
        if (pos == '0) slot <= cmd.first;
      end
      CELL_SPLIT: begin
        if (pos == cmd.idx) slot <= cmd.first;
        else if (pos == cmd.idx + SlotIdxW'(1)) slot <= cmd.second;
        else if (pos > cmd.idx) slot <= left_slot;
      end
      CELL_REMOVE: begin
        if (pos >= cmd.idx) slot <= right_slot;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/gasa_divider.sv =====
module gasa_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [gasa_pkg::DimW-1:0] dividend,
  input  logic [gasa_pkg::BlkW-1:0] divisor,
  output logic busy,
  output logic [gasa_pkg::DimW-1:0] quotient
);
  import gasa_pkg::*;

  logic [BlkW:0] rem;
  logic [DimW-1:0] num;
  logic [$clog2(DimW+1)-1:0] cnt;
  logic [BlkW:0] trial;

  assign trial = {rem[BlkW-1:0], num[DimW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= ($clog2(DimW+1))'(DimW);
      rem <= '0;
      num <= dividend;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[DimW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        quotient <= {quotient[DimW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[DimW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) busy <= 1'b0;
    end
  end
endmodule

// ===== rtl/guillotine_atlas_slot_allocator_unit.sv =====
// Guillotine atlas slot allocator. Each item takes one start pulse and gives
// exactly one result strobe. A clear goes from the accepting state straight
// to the result state. An allocation goes through the accepting state, two
// serial block divisions, padding, a scan of the free slots one per cycle up
// to and including the chosen one (every listed slot when none fits), and the
// result state. busy stays high through the result cycle, and the receiver
// must take the result in that cycle. The free list is a chain of slot cells
// that shift toward or away from the chosen slot.
module guillotine_atlas_slot_allocator_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  gasa_pkg::req_t req,
  output logic busy,
  output logic done,
  output gasa_pkg::res_t res,
  input  logic cfg_we,
  input  logic [gasa_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [gasa_pkg::DimW-1:0] cfg_data
);
  import gasa_pkg::*;

  logic [DimW-1:0] atlas_width, atlas_height;
  logic [BlkW-1:0] block_width, block_height;
  logic [CountW-1:0] free_count;
  logic any_allocated;
  state_t state, state_next;
  req_t rq;
  logic [BlkW-1:0] bw, bh;
  logic div_start, div_busy, div_sel, div_go, div_pending;
  logic [DimW-1:0] quot, div_in;
  logic [BlkW-1:0] div_dv;
  logic [DimW:0] cols_w, cols_h;
  logic [DimW:0] pw, ph;
  logic [SlotIdxW-1:0] scan_idx;
  slot_t cur, chosen;
  slot_t cells [MaxSlots];
  cell_cmd_t cmd;
  logic [DimW-1:0] lw, lh;
  logic fits;

  assign bw = (block_width == '0) ? BlkW'(1) : block_width;
  assign bh = (block_height == '0) ? BlkW'(1) : block_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= DimW'(AtlasReset);
      atlas_height <= DimW'(AtlasReset);
      block_width <= BlkW'(1);
      block_height <= BlkW'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegAtlasWidth: atlas_width <= cfg_data;
        RegAtlasHeight: atlas_height <= cfg_data;
        RegBlockWidth: block_width <= cfg_data[BlkW-1:0];
        RegBlockHeight: block_height <= cfg_data[BlkW-1:0];
        default: ;
      endcase
    end
  end

  assign div_in = div_sel ? rq.req_height : rq.req_width;
  assign div_dv = div_sel ? bh : bw;

  gasa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .divisor(div_dv), .busy(div_busy), .quotient(quot)
  );

  genvar g;
  generate
    for (g = 0; g < MaxSlots; g++) begin : g_cell
      gasa_cell u_cell (
        .clk(clk), .pos(SlotIdxW'(g)), .cmd(cmd),
        .left_slot(cells[(g == 0) ? 0 : g - 1]),
        .right_slot(cells[(g == MaxSlots - 1) ? g : g + 1]),
        .slot(cells[g])
      );
    end
  endgenerate

  assign cur = cells[scan_idx];
  assign fits = (pw <= {1'b0, cur.w}) && (ph <= {1'b0, cur.h});
  assign lw = DimW'({1'b0, chosen.w} - pw);
  assign lh = DimW'({1'b0, chosen.h} - ph);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      free_count <= CountW'(1);
      any_allocated <= 1'b0;
      div_sel <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start && req.op == OpClear) begin
        free_count <= CountW'(1);
        any_allocated <= 1'b0;
      end
      if (state == ST_SPLIT && cmd.op != CELL_HOLD) begin
        any_allocated <= 1'b1;
        if (cmd.op == CELL_SPLIT)
          free_count <= free_count + CountW'(1);
        else
          free_count <= free_count - CountW'(1);
      end
      if (div_go) div_sel <= ~div_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      rq <= req;
      scan_idx <= '0;
    end
    if (div_go) begin
      if (div_sel) cols_h <= {1'b0, quot} + 1'b1;
      else cols_w <= {1'b0, quot} + 1'b1;
    end
    if (state == ST_MUL) begin
      pw <= (DimW+1)'(((!any_allocated && rq.req_width == atlas_width) ?
             cols_w - 1'b1 : cols_w) * bw);
      ph <= (DimW+1)'(((!any_allocated && rq.req_height == atlas_height) ?
             cols_h - 1'b1 : cols_h) * bh);
    end
    if (state == ST_SCAN) begin
      chosen <= cur;
      if (!fits) scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) div_pending <= 1'b0;
    else if (div_start) div_pending <= 1'b1;
    else if (div_go) div_pending <= 1'b0;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_go = 1'b0;
    cmd = '0;
    cmd.op = CELL_HOLD;
    cmd.idx = scan_idx;
    done = 1'b0;
    res = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.op == OpClear) begin
            cmd.op = CELL_LOAD;
            cmd.first = '{x: '0, y: '0, w: atlas_width, h: atlas_height};
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_pending) begin
          div_start = 1'b1;
        end else if (!div_busy) begin
          div_go = 1'b1;
          if (div_sel) state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SCAN;
      ST_SCAN: begin
        if ({1'b0, scan_idx} >= free_count || free_count == '0) begin
          state_next = ST_DONE;
        end else if (fits) begin
          state_next = ST_SPLIT;
        end else if ({1'b0, scan_idx} == CountW'(MaxSlots - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_SPLIT: begin
        state_next = ST_IDLE;
        done = 1'b1;
        res.place_x = chosen.x[CoordW-1:0];
        res.place_y = chosen.y[CoordW-1:0];
        if (lh >= DimW'(MinSlotDim) || lw >= DimW'(MinSlotDim)) begin
          if (free_count == CountW'(MaxSlots)) begin
            res = '0;
            res.status = StatusFull;
          end else begin
            cmd.op = CELL_SPLIT;
            if (lh <= lw) begin
              cmd.first = '{x: chosen.x, y: chosen.y + ph[DimW-1:0],
                            w: pw[DimW-1:0], h: lh};
              cmd.second = '{x: chosen.x + pw[DimW-1:0], y: chosen.y,
                             w: lw, h: chosen.h};
            end else begin
              cmd.first = '{x: chosen.x + pw[DimW-1:0], y: chosen.y,
                            w: lw, h: ph[DimW-1:0]};
              cmd.second = '{x: chosen.x, y: chosen.y + ph[DimW-1:0],
                             w: chosen.w, h: lh};
            end
          end
        end else begin
          cmd.op = CELL_REMOVE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
        done = 1'b1;
        res.status = (rq.op == OpClear) ? StatusOk : StatusNotFound;
      end
      default: state_next = ST_IDLE;
    endcase
    if (rst) begin
      cmd.op = CELL_LOAD;
      cmd.first = '{x: '0, y: '0, w: DimW'(AtlasReset), h: DimW'(AtlasReset)};
    end
  end

`ifndef SYNTH
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPLIT && free_count == CountW'(MaxSlots) &&
     (lh >= DimW'(MinSlotDim) || lw >= DimW'(MinSlotDim))) |-> cmd.op == CELL_HOLD)
    else $error("split on full list");
  a_count: assert property (@(posedge clk) disable iff (rst)
    free_count <= CountW'(MaxSlots)) else $error("count overflow");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
`endif

endmodule
